[rtl/bq_pkg.sv]
// ----------------------------------------------------------------------------
// bq_pkg
// Shared widths, control structs and saturation helpers for the biquad cascade.
// ----------------------------------------------------------------------------
package bq_pkg;

  localparam int unsigned HistBits  = 24;  // stored history and section output
  localparam int unsigned CoefBits  = 32;  // Q2.30 coefficients
  localparam int unsigned GainBits  = 16;  // unsigned Q1.15 output gain
  localparam int unsigned OpndBits  = 27;  // serial operand, holds x +/- 2*x1 + x2
  localparam int unsigned AccBits   = 64;  // product sum
  localparam int unsigned CntBits   = $clog2(OpndBits);
  localparam int unsigned CfgIdxBits = 3;

  localparam int unsigned DefChannels   = 2;
  localparam int unsigned DefSampleBits = 24;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegLpfB0   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegLpfA1   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegLpfA2   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegHpfB0   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegHpfA1   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegHpfA2   = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegEnables = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegGain    = 3'd7;

  typedef struct packed {
    logic start;  // load operand and coefficient, begin a product
    logic clr;    // zero the sum when starting
  } bq_mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse: sum holds the finished product
  } bq_mac_st_t;

  function automatic logic signed [HistBits-1:0] sat_hist(input logic signed [AccBits-1:0] v);
    logic signed [AccBits-1:0] hi;
    logic signed [AccBits-1:0] lo;
    hi = (64'sd1 <<< (HistBits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) sat_hist = hi[HistBits-1:0];
    else if (v < lo) sat_hist = lo[HistBits-1:0];
    else sat_hist = v[HistBits-1:0];
  endfunction

endpackage

[rtl/bq_mac.sv]
// ----------------------------------------------------------------------------
// bq_mac
// Bit-serial multiply-accumulate: one operand bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module bq_mac import bq_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bq_mac_ctl_t                ctl_i,
  input  logic signed [CoefBits-1:0] coef_i,
  input  logic signed [OpndBits-1:0] opnd_i,
  output bq_mac_st_t                 st_o,
  output logic signed [AccBits-1:0]  acc_o
);

  logic signed [AccBits-1:0]  mcand_q, mcand_d;
  logic signed [AccBits-1:0]  acc_q, acc_d;
  logic        [OpndBits-1:0] mplier_q, mplier_d;
  logic        [CntBits-1:0]  cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       last;

  assign last = (cnt_q == CntBits'(OpndBits - 1));

  always_comb begin
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (busy_q) begin
      // sign bit of the operand carries negative weight
      if (mplier_q[0]) begin
        acc_d = last ? acc_q - mcand_q : acc_q + mcand_q;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + CntBits'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (ctl_i.start) begin
      mcand_d  = AccBits'(coef_i);
      mplier_d = opnd_i;
      cnt_d    = '0;
      busy_d   = 1'b1;
      if (ctl_i.clr) acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    mplier_q <= mplier_d;
  end

  assign st_o  = '{busy: busy_q, done: done_q};
  assign acc_o = acc_q;

endmodule

[rtl/biquad_lowpass_highpass_cascade_top.sv]
// ----------------------------------------------------------------------------
// biquad_lowpass_highpass_cascade_top
// Low-pass then high-pass direct form I biquads with gain and saturation.
// ----------------------------------------------------------------------------
// Each serial product loads its operand, shifts through its 27 operand bits, then signals done.
//   An enabled section runs three products (b0 on x +/- 2*x1 + x2, a1 on -y1, a2 on -y2)
//   between its control states; a skipped one only passes through. The gain product
//   and the output load follow both sections.
// Throughput: one transaction at a time; the next can be taken in the cycle after
//   the result loads.
// Reset: asynchronous, active low; clears histories, registers to defaults.
module biquad_lowpass_highpass_cascade_top import bq_pkg::*; #(
  parameter int unsigned CHANNELS    = DefChannels,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CoefBits-1:0]   cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // [23:0] sample_in
  input  logic [1:0]            s_axis_tuser,   // [0] channel, [1] clear_history
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [23:0] sample_out
  output logic                  m_axis_tuser    // [0] channel_out
);

  localparam int unsigned OutBits = (SAMPLE_BITS < 24) ? SAMPLE_BITS : 24;
  localparam int unsigned RowBits = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [AccBits-1:0] OutHi = (64'sd1 <<< (OutBits - 1)) - 64'sd1;
  localparam logic signed [AccBits-1:0] OutLo = -OutHi - 64'sd1;

  typedef enum logic [2:0] {
    S_IDLE, S_SEC, S_TERM, S_WAIT, S_ROUND, S_GAIN, S_GWAIT, S_OUT
  } state_e;

  // configuration registers
  logic signed [CoefBits-1:0] lpf_b0_q, lpf_a1_q, lpf_a2_q;
  logic signed [CoefBits-1:0] hpf_b0_q, hpf_a1_q, hpf_a2_q;
  logic [1:0]                 enables_q;
  logic [GainBits-1:0]        gain_q;

  // history: [section][channel][x1, x2, y1, y2]
  logic signed [HistBits-1:0] hist_q [2][CHANNELS][4];

  state_e                     state_q;
  logic                       sec_q;
  logic [1:0]                 term_q;
  logic [RowBits-1:0]         row_q;
  logic                       ch_q;
  logic signed [HistBits-1:0] xs_q;   // input of the running section
  logic                       out_valid_q;
  logic [23:0]                out_data_q;
  logic                       out_ch_q;

  bq_mac_ctl_t                mac_ctl;
  bq_mac_st_t                 mac_st;
  logic signed [CoefBits-1:0] mac_coef;
  logic signed [OpndBits-1:0] mac_opnd;
  logic signed [AccBits-1:0]  mac_acc;

  logic signed [HistBits-1:0] x1, x2, y1, y2;
  logic signed [OpndBits-1:0] ff_sum;
  logic signed [AccBits-1:0]  sec_shift, gain_shift;
  logic signed [HistBits-1:0] sec_y;
  logic signed [AccBits-1:0]  gain_sat;
  logic                       in_fire;
  logic [RowBits-1:0]         in_row;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  // channel numbers past CHANNELS wrap onto the history sets
  assign in_row        = (CHANNELS > 1) ? RowBits'(s_axis_tuser[0]) : '0;

  assign x1 = hist_q[sec_q][row_q][0];
  assign x2 = hist_q[sec_q][row_q][1];
  assign y1 = hist_q[sec_q][row_q][2];
  assign y2 = hist_q[sec_q][row_q][3];

  // fold the feedforward taps: low-pass x + 2*x1 + x2, high-pass x - 2*x1 + x2
  always_comb begin
    if (sec_q) ff_sum = OpndBits'(xs_q) - (OpndBits'(x1) <<< 1) + OpndBits'(x2);
    else       ff_sum = OpndBits'(xs_q) + (OpndBits'(x1) <<< 1) + OpndBits'(x2);
  end

  // operand and coefficient for the serial unit
  always_comb begin
    mac_ctl.start = (state_q == S_TERM) || (state_q == S_GAIN);
    mac_ctl.clr   = (state_q == S_GAIN) || (term_q == 2'd0);
    mac_coef      = '0;
    mac_opnd      = '0;
    if (state_q == S_GAIN) begin
      mac_coef = CoefBits'(gain_q);
      mac_opnd = OpndBits'(xs_q);
    end else begin
      case (term_q)
        2'd0: begin
          mac_coef = sec_q ? hpf_b0_q : lpf_b0_q;
          mac_opnd = ff_sum;
        end
        2'd1: begin
          mac_coef = sec_q ? hpf_a1_q : lpf_a1_q;
          mac_opnd = -OpndBits'(y1);
        end
        default: begin
          mac_coef = sec_q ? hpf_a2_q : lpf_a2_q;
          mac_opnd = -OpndBits'(y2);
        end
      endcase
    end
  end

  bq_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (mac_coef),
    .opnd_i (mac_opnd),
    .st_o   (mac_st),
    .acc_o  (mac_acc)
  );

  // round half up, then saturate
  assign sec_shift  = (mac_acc + (64'sd1 <<< 29)) >>> 30;
  assign sec_y      = sat_hist(sec_shift);
  assign gain_shift = (mac_acc + (64'sd1 <<< 14)) >>> 15;
  always_comb begin
    if (gain_shift > OutHi)      gain_sat = OutHi;
    else if (gain_shift < OutLo) gain_sat = OutLo;
    else                         gain_sat = gain_shift;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpf_b0_q  <= 32'sh4000_0000;
      lpf_a1_q  <= '0;
      lpf_a2_q  <= '0;
      hpf_b0_q  <= 32'sh4000_0000;
      hpf_a1_q  <= '0;
      hpf_a2_q  <= '0;
      enables_q <= '0;
      gain_q    <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLpfB0:   lpf_b0_q  <= cfg_data_i;
        RegLpfA1:   lpf_a1_q  <= cfg_data_i;
        RegLpfA2:   lpf_a2_q  <= cfg_data_i;
        RegHpfB0:   hpf_b0_q  <= cfg_data_i;
        RegHpfA1:   hpf_a1_q  <= cfg_data_i;
        RegHpfA2:   hpf_a2_q  <= cfg_data_i;
        RegEnables: enables_q <= cfg_data_i[1:0];
        RegGain:    gain_q    <= cfg_data_i[GainBits-1:0];
        default:    ;
      endcase
    end
  end

  // sequencer, history and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sec_q       <= 1'b0;
      term_q      <= '0;
      row_q       <= '0;
      ch_q        <= 1'b0;
      xs_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_ch_q    <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          for (int k = 0; k < 4; k++) hist_q[s][c][k] <= '0;
        end
      end
    end else begin
      // drop valid once taken, unless a new result loads in the same cycle
      if (m_axis_tvalid && m_axis_tready && (state_q != S_OUT)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            xs_q    <= s_axis_tdata;
            ch_q    <= s_axis_tuser[0];
            row_q   <= in_row;
            sec_q   <= 1'b0;
            state_q <= S_SEC;
            if (s_axis_tuser[1]) begin
              for (int k = 0; k < 4; k++) begin
                hist_q[0][in_row][k] <= '0;
                hist_q[1][in_row][k] <= '0;
              end
            end
          end
        end
        S_SEC: begin
          // skip a disabled section: sample passes, history holds
          term_q <= '0;
          if (enables_q[sec_q]) state_q <= S_TERM;
          else if (sec_q)       state_q <= S_GAIN;
          else                  sec_q   <= 1'b1;
        end
        S_TERM: state_q <= S_WAIT;
        S_WAIT: begin
          if (mac_st.done) begin
            if (term_q == 2'd2) state_q <= S_ROUND;
            else begin
              term_q  <= term_q + 2'd1;
              state_q <= S_TERM;
            end
          end
        end
        S_ROUND: begin
          hist_q[sec_q][row_q][0] <= xs_q;
          hist_q[sec_q][row_q][1] <= x1;
          hist_q[sec_q][row_q][2] <= sec_y;
          hist_q[sec_q][row_q][3] <= y1;
          xs_q   <= sec_y;
          term_q <= '0;
          if (sec_q) state_q <= S_GAIN;
          else begin
            sec_q   <= 1'b1;
            state_q <= S_SEC;
          end
        end
        S_GAIN:  state_q <= S_GWAIT;
        S_GWAIT: if (mac_st.done) state_q <= S_OUT;
        S_OUT: begin
          // hold the sum until the output register frees up
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= gain_sat[23:0];
            out_ch_q    <= ch_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ch_q;

`ifndef ASSERT_OFF
  a_idle_mac_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mac_st.busy) else $error("serial unit busy while idle");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_st.done |-> $past(mac_st.busy)) else $error("product done without work");
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || m_axis_tready)) |=> m_axis_tvalid)
    else $error("result not presented");
  a_wait_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT || state_q == S_GWAIT) |-> (mac_st.busy || mac_st.done))
    else $error("waiting on an idle serial unit");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the low-pass / high-pass biquad cascade: drives
// directed and random audio samples over the input stream, tracks filter
// history and coefficients in its own model, and checks every output sample.
// ----------------------------------------------------------------------------
module tb;
  import bq_pkg::*;

  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned DrainCycles = 300;   // longer than one both-on pass
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned PhaseItems  = 130;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CoefBits-1:0]   cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;   // [23:0] sample_in
  logic [1:0]            s_axis_tuser;   // [0] channel, [1] clear_history
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;   // [23:0] sample_out
  logic                  m_axis_tuser;   // [0] channel_out

  biquad_lowpass_highpass_cascade_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Filter model state: coefficients, enables, gain and per-channel history.
  // History slots per channel: x[n-1], x[n-2], y[n-1], y[n-2].
  longint coef_lp_b0, coef_lp_a1, coef_lp_a2;
  longint coef_hp_b0, coef_hp_a1, coef_hp_a2;
  int unsigned stage_en;
  longint      out_gain;
  longint      lp_hist [2][4];
  longint      hp_hist [2][4];

  // Output samples still to come, oldest first.
  logic [23:0] pending_sample_q[$];
  logic        pending_chan_q[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left;
  int unsigned gap_max;
  bit          valid_high;

  function automatic longint sat24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // One direct form I section; updates the chosen history set in place.
  function automatic longint biquad_section(input bit hp, input int c, input longint x);
    longint b0, a1, a2, acc, y;
    longint h[4];
    b0 = hp ? coef_hp_b0 : coef_lp_b0;
    a1 = hp ? coef_hp_a1 : coef_lp_a1;
    a2 = hp ? coef_hp_a2 : coef_lp_a2;
    if (hp) h = hp_hist[c];
    else h = lp_hist[c];
    acc = b0 * x + (hp ? -2 : 2) * b0 * h[0] + b0 * h[1] - a1 * h[2] - a2 * h[3];
    y = sat24((acc + (64'sd1 <<< 29)) >>> 30);
    h[1] = h[0];
    h[0] = x;
    h[3] = h[2];
    h[2] = y;
    if (hp) hp_hist[c] = h;
    else lp_hist[c] = h;
    return y;
  endfunction

  function automatic logic [23:0] filter_sample(input logic [23:0] smp, input bit ch,
                                                 input bit clr);
    longint y;
    if (clr) begin
      for (int k = 0; k < 4; k++) begin
        lp_hist[ch][k] = 0;
        hp_hist[ch][k] = 0;
      end
    end
    y = longint'($signed(smp));
    if (stage_en[0]) y = biquad_section(1'b0, ch, y);
    if (stage_en[1]) y = biquad_section(1'b1, ch, y);
    y = sat24((y * out_gain + 64'sd16384) >>> 15);
    return y[23:0];
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Write one register and mirror it into the model.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegLpfB0:   coef_lp_b0 = longint'($signed(val));
      RegLpfA1:   coef_lp_a1 = longint'($signed(val));
      RegLpfA2:   coef_lp_a2 = longint'($signed(val));
      RegHpfB0:   coef_hp_b0 = longint'($signed(val));
      RegHpfA1:   coef_hp_a1 = longint'($signed(val));
      RegHpfA2:   coef_hp_a2 = longint'($signed(val));
      RegEnables: stage_en   = val[1:0];
      RegGain:    out_gain   = longint'(val[15:0]);
      default: ;
    endcase
  endtask

  // Drop valid, wait for every output, then let the block settle.
  task automatic wait_idle();
    if (valid_high) begin
      @(posedge clk_i);
      s_axis_tvalid <= 1'b0;
      valid_high = 1'b0;
    end
    while (pending_sample_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offer one sample; on acceptance queue its expected output. A typed
  // expectation overrides the model value (the model still advances).
  task automatic send_sample(input logic [23:0] smp, input bit ch, input bit clr,
                             input bit typed, input logic [23:0] want);
    logic [23:0] pred;
    if (!valid_high) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= {clr, ch};
    valid_high = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = filter_sample(smp, ch, clr);
    pending_sample_q.push_back(typed ? want : pred);
    pending_chan_q.push_back(ch);
    // At the end of a burst, hold valid low for a random gap if gap_max allows one.
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (gap_max > 0) begin
        s_axis_tvalid <= 1'b0;
        valid_high = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [31:0] pick_coef(input bit feedback);
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      3: return 32'h0;
      default: return feedback ? 32'(-$urandom_range(0, 32'h7000_0000))
                               : 32'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7f_ffff;
      1: return 24'h80_0000;
      2: return 24'(32'($urandom_range(0, 64)) - 32);
      default: return $urandom();
    endcase
  endfunction

  // Receiver: stall pattern follows cycles[9:8]; check each transaction.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
    case (cycles[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= $urandom_range(0, 1);
      2'd2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sample_q.size() == 0) begin
        report_mismatch("unexpected output sample", longint'($signed(m_axis_tdata)), 0);
      end else begin
        if (m_axis_tdata !== pending_sample_q[0])
          report_mismatch("sample_out", longint'($signed(m_axis_tdata)),
                          longint'($signed(pending_sample_q[0])));
        if (m_axis_tuser !== pending_chan_q[0])
          report_mismatch("channel_out", m_axis_tuser, pending_chan_q[0]);
        void'(pending_sample_q.pop_front());
        void'(pending_chan_q.pop_front());
      end
    end
  end

  typedef struct packed {
    logic [23:0] smp;
    logic        ch;
    logic        clr;
    logic        typed;
    logic [23:0] want;
  } stim_row_t;

  // Rows 0-7 run at reset defaults (both sections off, gain one half), so
  // the output is the input halved with round half up. Later rows run with
  // both sections on and are checked against the model.
  localparam int unsigned DirRows = 16;
  stim_row_t dir_rows [DirRows] = '{
    '{24'h7f_ffff, 1'b0, 1'b0, 1'b1, 24'h40_0000},
    '{24'h80_0000, 1'b1, 1'b0, 1'b1, 24'hc0_0000},
    '{24'h00_0001, 1'b0, 1'b1, 1'b1, 24'h00_0001},
    '{24'hff_ffff, 1'b1, 1'b1, 1'b1, 24'h00_0000},
    '{24'h00_0000, 1'b0, 1'b0, 1'b1, 24'h00_0000},
    '{24'h00_0003, 1'b1, 1'b0, 1'b1, 24'h00_0002},
    '{24'hff_fffd, 1'b0, 1'b0, 1'b1, 24'hff_ffff},
    '{24'h55_5555, 1'b1, 1'b1, 1'b1, 24'h2a_aaab},
    '{24'h7f_ffff, 1'b0, 1'b0, 1'b0, 24'h0},
    '{24'h7f_ffff, 1'b0, 1'b0, 1'b0, 24'h0},
    '{24'h80_0000, 1'b1, 1'b0, 1'b0, 24'h0},
    '{24'h80_0000, 1'b1, 1'b0, 1'b0, 24'h0},
    '{24'h12_3456, 1'b0, 1'b0, 1'b0, 24'h0},
    '{24'h12_3456, 1'b0, 1'b1, 1'b0, 24'h0},
    '{24'h00_0000, 1'b1, 1'b1, 1'b0, 24'h0},
    '{24'hab_cdef, 1'b1, 1'b0, 1'b0, 24'h0}
  };

  initial begin
    logic [31:0] gain_pick;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegLpfB0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    valid_high    = 1'b0;
    burst_left    = 1;
    gap_max       = 3;
    coef_lp_b0 = 64'sd1073741824; coef_lp_a1 = 0; coef_lp_a2 = 0;
    coef_hp_b0 = 64'sd1073741824; coef_hp_a1 = 0; coef_hp_a2 = 0;
    stage_en = 0;
    out_gain = 16384;
    for (int c = 0; c < 2; c++)
      for (int k = 0; k < 4; k++) begin
        lp_hist[c][k] = 0;
        hp_hist[c][k] = 0;
      end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part; switch both sections on at unity gain halfway through.
    for (int i = 0; i < DirRows; i++) begin
      if (i == 8) begin
        wait_idle();
        write_reg(RegLpfB0, 32'h0400_0000);
        write_reg(RegLpfA1, 32'h9000_0000);
        write_reg(RegLpfA2, 32'h2000_0000);
        write_reg(RegHpfB0, 32'h3000_0000);
        write_reg(RegHpfA1, 32'h8000_0000);
        write_reg(RegHpfA2, 32'h7fff_ffff);
        write_reg(RegEnables, 32'd3);
        write_reg(RegGain, 32'd32768);
      end
      send_sample(dir_rows[i].smp, dir_rows[i].ch, dir_rows[i].clr,
                  dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each with its own coefficients, enables, gain and pacing.
    for (int p = 0; p < RandPhases; p++) begin
      wait_idle();
      write_reg(RegLpfB0, pick_coef(1'b0));
      write_reg(RegLpfA1, pick_coef(1'b1));
      write_reg(RegLpfA2, pick_coef(1'b0));
      write_reg(RegHpfB0, pick_coef(1'b0));
      write_reg(RegHpfA1, pick_coef(1'b1));
      write_reg(RegHpfA2, pick_coef(1'b0));
      write_reg(RegEnables, (p < 4) ? p : $urandom_range(0, 3));
      case (p % 5)
        0: gain_pick = 32'd32768;
        1: gain_pick = 32'd0;
        2: gain_pick = 32'd65535;
        default: gain_pick = $urandom();
      endcase
      write_reg(RegGain, gain_pick);
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 40);
      for (int n = 0; n < PhaseItems; n++)
        send_sample(pick_sample(), $urandom_range(0, 1), ($urandom_range(0, 19) == 0),
                    1'b0, 24'h0);
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
